>>> src/lru_image_tile_cache_core_macros.svh
// Assertion macros for the tile cache RTL, included by lruc_back.
// Define ASSERT_OFF to compile the checks out.
`ifndef LRU_IMAGE_TILE_CACHE_CORE_MACROS_SVH
`define LRU_IMAGE_TILE_CACHE_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define LRUC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define LRUC_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define LRUC_ASSERT(lbl, clk, rst, prop, msg)
`define LRUC_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

>>> src/lruc_pkg.sv
// Shared types and constants for the LRU image tile cache.
// No dependencies.
package lruc_pkg;

   localparam int TILE_EDGE_DEF   = 256;
   localparam int CACHE_SLOTS_DEF = 64;
   localparam int TILE_COUNT_DEF  = 4096;

   localparam int QUEUE_DEPTH  = 2;
   localparam int TILE_FIELD_W = 16;
   localparam int CSR_DATA_W   = 15;

   localparam logic [14:0] WIDTH_RESET  = 15'd1;
   localparam logic [14:0] HEIGHT_RESET = 15'd1;
   localparam logic [2:0]  BPP_RESET    = 3'd1;
   localparam logic [6:0]  MAXT_RESET   = 7'd64;

   typedef enum logic [1:0] {
      CSR_IMAGE_WIDTH      = 2'd0,
      CSR_IMAGE_HEIGHT     = 2'd1,
      CSR_BYTES_PER_PIXEL  = 2'd2,
      CSR_MAX_CACHED_TILES = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic        func;
      logic [13:0] x_pos;
      logic [13:0] y_pos;
   } req_type;

   typedef struct packed {
      logic        error;
      logic [5:0]  slot;
      logic [17:0] byte_offset;
      logic        miss;
      logic [11:0] tile_index;
      logic        evict_valid;
      logic [11:0] evicted_tile;
      logic        write_back;
      logic        load_from_swap;
   } rsp_type;

   // classified access handed from front to back
   typedef struct packed {
      logic                    error;
      logic                    func;
      logic [TILE_FIELD_W-1:0] tile;
      logic [17:0]             byte_offset;
   } mid_type;

endpackage

>>> src/lru_image_tile_cache_core.sv
// Top level of the LRU image tile cache: CSRs, front, queues and back.
// Depends on lruc_pkg, lruc_front, lruc_fifo and lruc_back.
//
// Usage: push one pixel access (func, x_pos, y_pos) on req_* while req_full
// is low. Each access yields one transaction on rsp_*: pop it while
// rsp_empty is low. CSRs are written through csr_write/csr_index/csr_data
// only while the block is idle: the user must ensure it, the block does not.
// The front classifies an access in the push cycle. The back reads the tile
// entry in ST_IDLE, answers a hit or a miss into a free slot in ST_LOOKUP,
// a miss that evicts via ST_EVRD, ST_EVWR and ST_COMMIT, and an
// out-of-range access from ST_IDLE; it takes no new access until the last
// is done. The tile table's single write port and the read-then-write of
// each entry set these steps. After reset the back sweeps the tile table
// (TILE_COUNT entries, 4096 by default); accesses queue up meanwhile and
// req_full holds them off. When the receiver stalls, the result queue
// fills, the back holds, the request queue fills and req_full rises.
module lru_image_tile_cache_core #(
   parameter int TILE_EDGE   = lruc_pkg::TILE_EDGE_DEF,
   parameter int CACHE_SLOTS = lruc_pkg::CACHE_SLOTS_DEF,
   parameter int TILE_COUNT  = lruc_pkg::TILE_COUNT_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  lruc_pkg::req_type             req_data,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output lruc_pkg::rsp_type             rsp_data,
   input  logic                          csr_write,
   input  lruc_pkg::csr_index_type       csr_index,
   input  logic [lruc_pkg::CSR_DATA_W-1:0] csr_data
);
   import lruc_pkg::*;

   logic [14:0] width_ff, height_ff;
   logic [2:0]  bpp_ff;
   logic [6:0]  maxt_ff;

   mid_type     front_mid, back_mid;
   logic [$bits(mid_type)-1:0] back_mid_vec;
   logic        mid_empty, mid_pop;
   rsp_type     back_rsp;
   logic [$bits(rsp_type)-1:0] rsp_vec;
   logic        out_full, out_push;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         bpp_ff    <= BPP_RESET;
         maxt_ff   <= MAXT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:      width_ff  <= csr_data;
            CSR_IMAGE_HEIGHT:     height_ff <= csr_data;
            CSR_BYTES_PER_PIXEL:  bpp_ff    <= csr_data[2:0];
            CSR_MAX_CACHED_TILES: maxt_ff   <= csr_data[6:0];
            default: ;
         endcase
      end
   end

   lruc_front #(
      .TILE_EDGE  (TILE_EDGE),
      .TILE_COUNT (TILE_COUNT)
   ) u_front (
      .req_data   (req_data),
      .cfg_width  (width_ff),
      .cfg_height (height_ff),
      .cfg_bpp    (bpp_ff),
      .mid_data   (front_mid)
   );

   lruc_fifo #(
      .WIDTH ($bits(mid_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_mid_q (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (front_mid),
      .full      (req_full),
      .pop       (mid_pop),
      .pop_data  (back_mid_vec),
      .empty     (mid_empty)
   );

   assign back_mid = mid_type'(back_mid_vec);

   lruc_back #(
      .CACHE_SLOTS (CACHE_SLOTS),
      .TILE_COUNT  (TILE_COUNT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg_max   (maxt_ff),
      .mid_empty (mid_empty),
      .mid_pop   (mid_pop),
      .mid_data  (back_mid),
      .out_full  (out_full),
      .out_push  (out_push),
      .out_data  (back_rsp)
   );

   lruc_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (back_rsp),
      .full      (out_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_vec),
      .empty     (rsp_empty)
   );

   assign rsp_data = rsp_type'(rsp_vec);
endmodule

>>> src/lruc_fifo.sv
// Small register queue used between pipeline parts.
// Depends on nothing but its parameters.
module lruc_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] data_ff [DEPTH];
   logic [PW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = data_ff[rd_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         data_ff[wr_ff] <= push_data;
      end
   end
endmodule

>>> src/lruc_front.sv
// Front part: range check, tile index and byte offset of one pixel access.
// Depends on lruc_pkg. TILE_EDGE is a power of two.
module lruc_front #(
   parameter int TILE_EDGE  = lruc_pkg::TILE_EDGE_DEF,
   parameter int TILE_COUNT = lruc_pkg::TILE_COUNT_DEF
) (
   input  lruc_pkg::req_type req_data,
   input  logic [14:0]       cfg_width,
   input  logic [14:0]       cfg_height,
   input  logic [2:0]        cfg_bpp,
   output lruc_pkg::mid_type mid_data
);
   import lruc_pkg::*;

   logic [15:0] wsum;
   logic [14:0] across;
   logic [13:0] tx, ty, col, row;
   logic [29:0] idx_full;
   logic [23:0] pix, boff;
   logic [2:0]  bpp;
   logic        outside;

   always_comb begin
      wsum     = {1'b0, cfg_width} + 16'(TILE_EDGE - 1);
      across   = 15'(wsum / TILE_EDGE);
      tx       = 14'(req_data.x_pos / TILE_EDGE);
      ty       = 14'(req_data.y_pos / TILE_EDGE);
      col      = 14'(req_data.x_pos % TILE_EDGE);
      row      = 14'(req_data.y_pos % TILE_EDGE);
      idx_full = 30'(ty) * 30'(across) + 30'(tx);
      // clamp odd pixel sizes into 1..4
      if (cfg_bpp == 3'd0) begin
         bpp = 3'd1;
      end else if (cfg_bpp > 3'd4) begin
         bpp = 3'd4;
      end else begin
         bpp = cfg_bpp;
      end
      pix  = 24'(row) * 24'(TILE_EDGE) + 24'(col);
      boff = 24'(bpp) * pix;
      outside = ({1'b0, req_data.x_pos} >= cfg_width)
             || ({1'b0, req_data.y_pos} >= cfg_height)
             || (idx_full >= 30'(TILE_COUNT));
      mid_data.error       = outside;
      mid_data.func        = req_data.func;
      mid_data.tile        = TILE_FIELD_W'(idx_full);
      mid_data.byte_offset = 18'(boff);
   end
endmodule

>>> src/lruc_back.sv
// Back part: tile table lookup, LRU slot choice, eviction and recency update.
// Depends on lruc_pkg and the assertion macros header.
`include "lru_image_tile_cache_core_macros.svh"
module lruc_back #(
   parameter int CACHE_SLOTS = lruc_pkg::CACHE_SLOTS_DEF,
   parameter int TILE_COUNT  = lruc_pkg::TILE_COUNT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [6:0]        cfg_max,
   input  logic              mid_empty,
   output logic              mid_pop,
   input  lruc_pkg::mid_type mid_data,
   input  logic              out_full,
   output logic              out_push,
   output lruc_pkg::rsp_type out_data
);
   import lruc_pkg::*;

   localparam int SW  = $clog2(CACHE_SLOTS);
   localparam int NW  = $clog2(CACHE_SLOTS + 1);
   localparam int TIW = $clog2(TILE_COUNT);
   localparam int EW  = SW + 3;

   typedef enum logic [5:0] {
      ST_CLEAR  = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_LOOKUP = 6'b000100,
      ST_EVRD   = 6'b001000,
      ST_EVWR   = 6'b010000,
      ST_COMMIT = 6'b100000
   } state_type;

   state_type      state_ff, state_in;
   logic [TIW-1:0] clr_ff, clr_in;
   logic [NW-1:0]  n_ff, n_in;
   logic [SW-1:0]  rank_ff [CACHE_SLOTS];
   logic [SW-1:0]  rank_in [CACHE_SLOTS];
   logic [SW-1:0]  lru_ff, lru_in;
   mid_type        cur_ff, cur_in;
   logic           swp_ff, swp_in, wb_ff, wb_in;
   logic [TIW-1:0] old_ff, old_in;

   logic [EW-1:0]  tile_mem [TILE_COUNT];
   logic [EW-1:0]  tile_rd_ff;
   logic [TIW-1:0] owner_mem [CACHE_SLOTS];
   logic [TIW-1:0] owner_rd_ff;

   logic [TIW-1:0] t_rd_addr, t_waddr;
   logic           t_we, o_we;
   logic [EW-1:0]  t_wdata;
   logic [SW-1:0]  o_waddr;
   logic [TIW-1:0] o_wdata;

   logic           upd;
   logic [SW-1:0]  upd_slot, upd_r;
   logic [NW-1:0]  upd_n;
   logic [CACHE_SLOTS-1:0] oldest_vec;

   logic           ent_valid, ent_dirty, ent_swp;
   logic [SW-1:0]  ent_slot, hit_slot;
   logic [8:0]     cap;
   logic           free;
   logic [TIW-1:0] cur_tile;

   assign ent_valid = tile_rd_ff[EW-1];
   assign ent_slot  = tile_rd_ff[EW-2:2];
   assign ent_dirty = tile_rd_ff[1];
   assign ent_swp   = tile_rd_ff[0];
   assign cur_tile  = TIW'(cur_ff.tile);

   always_comb begin
      if (cfg_max == 7'd0) begin
         cap = 9'd1;
      end else if ({2'b0, cfg_max} > 9'(CACHE_SLOTS)) begin
         cap = 9'(CACHE_SLOTS);
      end else begin
         cap = {2'b0, cfg_max};
      end
      free     = !ent_valid && (9'(n_ff) < cap);
      hit_slot = ent_valid ? ent_slot : SW'(n_ff);
   end

   // LRU slot holds the highest rank among slots in use
   always_comb begin
      lru_in = '0;
      for (int i = 0; i < CACHE_SLOTS; i++) begin
         oldest_vec[i] = (NW'(i) < n_ff) && (rank_ff[i] == SW'(n_ff - NW'(1)));
         if (oldest_vec[i]) begin
            lru_in = lru_in | SW'(i);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < CACHE_SLOTS; i++) begin
         rank_in[i] = rank_ff[i];
         if (upd) begin
            if (SW'(i) == upd_slot) begin
               rank_in[i] = '0;
            end else if ((NW'(i) < upd_n) && (rank_ff[i] < upd_r)) begin
               rank_in[i] = rank_ff[i] + SW'(1);
            end
         end
      end
   end

   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      n_in      = n_ff;
      cur_in    = cur_ff;
      swp_in    = swp_ff;
      wb_in     = wb_ff;
      old_in    = old_ff;
      mid_pop   = 1'b0;
      out_push  = 1'b0;
      out_data  = '0;
      t_rd_addr = TIW'(mid_data.tile);
      t_we      = 1'b0;
      t_waddr   = clr_ff;
      t_wdata   = '0;
      o_we      = 1'b0;
      o_waddr   = hit_slot;
      o_wdata   = cur_tile;
      upd       = 1'b0;
      upd_slot  = hit_slot;
      upd_r     = '0;
      upd_n     = n_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            t_we = 1'b1;
            if (clr_ff == TIW'(TILE_COUNT - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + TIW'(1);
            end
         end
         ST_IDLE: begin
            if (!mid_empty && !out_full) begin
               mid_pop = 1'b1;
               if (mid_data.error) begin
                  out_push       = 1'b1;
                  out_data.error = 1'b1;
               end else begin
                  cur_in   = mid_data;
                  state_in = ST_LOOKUP;
               end
            end
         end
         ST_LOOKUP: begin
            if (ent_valid || free) begin
               t_we    = 1'b1;
               t_waddr = cur_tile;
               t_wdata = {1'b1, hit_slot, ent_dirty | cur_ff.func, ent_swp};
               upd     = 1'b1;
               if (ent_valid) begin
                  upd_r = rank_ff[ent_slot];
               end else begin
                  o_we  = 1'b1;
                  upd_r = SW'(n_ff);
                  upd_n = n_ff + NW'(1);
                  n_in  = n_ff + NW'(1);
               end
               out_push                = 1'b1;
               out_data.slot           = 6'(hit_slot);
               out_data.byte_offset    = cur_ff.byte_offset;
               out_data.miss           = !ent_valid;
               out_data.tile_index     = 12'(cur_tile);
               out_data.load_from_swap = !ent_valid && ent_swp;
               state_in                = ST_IDLE;
            end else begin
               swp_in   = ent_swp;
               state_in = ST_EVRD;
            end
         end
         ST_EVRD: begin
            t_rd_addr = owner_rd_ff;
            old_in    = owner_rd_ff;
            state_in  = ST_EVWR;
         end
         ST_EVWR: begin
            // drop residency; a dirty tile moves to swap
            t_we     = 1'b1;
            t_waddr  = old_ff;
            t_wdata  = {1'b0, SW'(0), 1'b0, ent_swp | ent_dirty};
            wb_in    = ent_dirty;
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            t_we     = 1'b1;
            t_waddr  = cur_tile;
            t_wdata  = {1'b1, lru_ff, cur_ff.func, swp_ff};
            o_we     = 1'b1;
            o_waddr  = lru_ff;
            upd      = 1'b1;
            upd_slot = lru_ff;
            upd_r    = rank_ff[lru_ff];
            out_push                = 1'b1;
            out_data.slot           = 6'(lru_ff);
            out_data.byte_offset    = cur_ff.byte_offset;
            out_data.miss           = 1'b1;
            out_data.tile_index     = 12'(cur_tile);
            out_data.evict_valid    = 1'b1;
            out_data.evicted_tile   = 12'(old_ff);
            out_data.write_back     = wb_ff;
            out_data.load_from_swap = swp_ff;
            state_in                = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         n_ff     <= '0;
         for (int i = 0; i < CACHE_SLOTS; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         n_ff     <= n_in;
         for (int i = 0; i < CACHE_SLOTS; i++) begin
            rank_ff[i] <= rank_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      lru_ff <= lru_in;
      cur_ff <= cur_in;
      swp_ff <= swp_in;
      wb_ff  <= wb_in;
      old_ff <= old_in;
   end

   always_ff @(posedge clock) begin
      if (t_we) begin
         tile_mem[t_waddr] <= t_wdata;
      end
      tile_rd_ff <= tile_mem[t_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (o_we) begin
         owner_mem[o_waddr] <= o_wdata;
      end
      owner_rd_ff <= owner_mem[lru_ff];
   end

   `LRUC_ASSERT(a_count_bound, clock, reset, n_ff <= NW'(CACHE_SLOTS), "slot count overflow")
   `LRUC_ASSERT(a_lru_unique, clock, reset, (state_ff == ST_EVRD) |-> $onehot(oldest_vec), "no LRU")
   `LRUC_ASSERT(a_commit_order, clock, reset, (state_ff == ST_COMMIT) |-> ($past(state_ff) == ST_EVWR), "bad commit")
   `LRUC_NEVER(a_push_full, clock, reset, out_push && out_full, "result pushed into full queue")
endmodule
